[design/svau_pkg.sv]
package svau_pkg;

    // command codes
    localparam logic [3:0] CMD_CTRL_WR   = 4'd0;
    localparam logic [3:0] CMD_OTHER_WR  = 4'd1;
    localparam logic [3:0] CMD_SCROLL_WR = 4'd2;
    localparam logic [3:0] CMD_ADDR_WR   = 4'd3;
    localparam logic [3:0] CMD_DATA_WR   = 4'd4;
    localparam logic [3:0] CMD_DATA_RD   = 4'd5;
    localparam logic [3:0] CMD_STATUS_RD = 4'd6;
    localparam logic [3:0] CMD_INC_X     = 4'd7;
    localparam logic [3:0] CMD_INC_Y     = 4'd8;
    localparam logic [3:0] CMD_COPY_X    = 4'd9;
    localparam logic [3:0] CMD_COPY_Y    = 4'd10;
    localparam logic [3:0] CMD_SET_VBL   = 4'd11;
    localparam logic [3:0] CMD_CLR_VBL   = 4'd12;
    localparam logic [3:0] CMD_TICK      = 4'd13;

    // configuration register indexes
    localparam logic REG_NMI_DELAY = 1'b0;

    localparam logic [7:0] NMI_DELAY_RESET = 8'd15;

    // coarse x, coarse y and fine y wrap points
    localparam logic [4:0] COARSE_Y_LAST_ROW = 5'd29;
    localparam logic [4:0] COARSE_MAX        = 5'd31;
    localparam logic [2:0] FINE_Y_MAX        = 3'd7;

    typedef struct packed {
        logic [14:0] cur_addr;
        logic [14:0] tmp_addr;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic        inc_by_row;
        logic        nmi_enable;
        logic        vblank;
        logic        nmi_prev;
        logic [7:0]  nmi_count;
        logic [7:0]  bus_latch;
    } svau_state_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [14:0] vram_address;
        logic [2:0]  fine_x_scroll;
        logic        nmi_pulse;
    } svau_result_t;

endpackage

[design/svau_ifs.sv]
interface svau_cmd_if;
    logic       valid;
    logic       ready;
    logic [3:0] cmd;
    logic [7:0] data_byte;
    logic       sprite_overflow;
    logic       sprite_zero_hit;

    modport source (output valid, cmd, data_byte, sprite_overflow, sprite_zero_hit,
                    input ready);
    modport sink (input valid, cmd, data_byte, sprite_overflow, sprite_zero_hit,
                  output ready);
endinterface

interface svau_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic [14:0] vram_address;
    logic [2:0]  fine_x_scroll;
    logic        nmi_pulse;

    modport source (output valid, read_byte, vram_address, fine_x_scroll, nmi_pulse,
                    input ready);
    modport sink (input valid, read_byte, vram_address, fine_x_scroll, nmi_pulse,
                  output ready);
endinterface

[design/svau_core.sv]
module svau_core
(
    input  svau_pkg::svau_state_t  state,
    input  logic [3:0]             cmd,
    input  logic [7:0]             data_byte,
    input  logic                   sprite_overflow,
    input  logic                   sprite_zero_hit,
    input  logic [7:0]             nmi_delay,
    output svau_pkg::svau_state_t  state_next,
    output svau_pkg::svau_result_t result
);

    svau_pkg::svau_state_t nx;
    logic        check_edge;
    logic        nmi_cond;
    logic [7:0]  rd;
    logic        pulse;
    logic [7:0]  count_dec;
    logic [2:0]  fine_y;
    logic [4:0]  coarse_y;
    logic [14:0] step;

    assign fine_y    = state.cur_addr[14:12];
    assign coarse_y  = state.cur_addr[9:5];
    assign count_dec = state.nmi_count - 8'd1;
    assign step      = state.inc_by_row ? 15'd32 : 15'd1;

    always_comb
    begin
        nx         = state;
        rd         = 8'd0;
        pulse      = 1'b0;
        check_edge = 1'b0;

        if (cmd inside {[svau_pkg::CMD_CTRL_WR:svau_pkg::CMD_DATA_WR]})
        begin
            nx.bus_latch = data_byte;
        end

        case (cmd)
            svau_pkg::CMD_CTRL_WR:
            begin
                nx.inc_by_row       = data_byte[2];
                nx.nmi_enable       = data_byte[7];
                nx.tmp_addr[11:10]  = data_byte[1:0];
                check_edge          = 1'b1;
            end
            svau_pkg::CMD_SCROLL_WR:
            begin
                if (!state.write_toggle)
                begin
                    nx.tmp_addr[4:0] = data_byte[7:3];
                    nx.fine_x        = data_byte[2:0];
                    nx.write_toggle  = 1'b1;
                end
                else
                begin
                    nx.tmp_addr[14:12] = data_byte[2:0];
                    nx.tmp_addr[9:5]   = data_byte[7:3];
                    nx.write_toggle    = 1'b0;
                end
            end
            svau_pkg::CMD_ADDR_WR:
            begin
                if (!state.write_toggle)
                begin
                    nx.tmp_addr[14]   = 1'b0;
                    nx.tmp_addr[13:8] = data_byte[5:0];
                    nx.write_toggle   = 1'b1;
                end
                else
                begin
                    nx.tmp_addr[7:0] = data_byte;
                    nx.cur_addr      = {state.tmp_addr[14:8], data_byte};
                    nx.write_toggle  = 1'b0;
                end
            end
            svau_pkg::CMD_DATA_WR, svau_pkg::CMD_DATA_RD:
            begin
                nx.cur_addr = state.cur_addr + step;
            end
            svau_pkg::CMD_STATUS_RD:
            begin
                rd              = {state.vblank, sprite_zero_hit, sprite_overflow,
                                   state.bus_latch[4:0]};
                nx.vblank       = 1'b0;
                nx.write_toggle = 1'b0;
                check_edge      = 1'b1;
            end
            svau_pkg::CMD_INC_X:
            begin
                if (state.cur_addr[4:0] == svau_pkg::COARSE_MAX)
                begin
                    nx.cur_addr[4:0] = 5'd0;
                    nx.cur_addr[10]  = ~state.cur_addr[10];
                end
                else
                begin
                    nx.cur_addr[4:0] = state.cur_addr[4:0] + 5'd1;
                end
            end
            svau_pkg::CMD_INC_Y:
            begin
                if (fine_y != svau_pkg::FINE_Y_MAX)
                begin
                    nx.cur_addr[14:12] = fine_y + 3'd1;
                end
                else
                begin
                    nx.cur_addr[14:12] = 3'd0;
                    if (coarse_y == svau_pkg::COARSE_Y_LAST_ROW)
                    begin
                        nx.cur_addr[9:5] = 5'd0;
                        nx.cur_addr[11]  = ~state.cur_addr[11];
                    end
                    else if (coarse_y == svau_pkg::COARSE_MAX)
                    begin
                        nx.cur_addr[9:5] = 5'd0;
                    end
                    else
                    begin
                        nx.cur_addr[9:5] = coarse_y + 5'd1;
                    end
                end
            end
            svau_pkg::CMD_COPY_X:
            begin
                nx.cur_addr[10]  = state.tmp_addr[10];
                nx.cur_addr[4:0] = state.tmp_addr[4:0];
            end
            svau_pkg::CMD_COPY_Y:
            begin
                nx.cur_addr[14:11] = state.tmp_addr[14:11];
                nx.cur_addr[9:5]   = state.tmp_addr[9:5];
            end
            svau_pkg::CMD_SET_VBL:
            begin
                nx.vblank  = 1'b1;
                check_edge = 1'b1;
            end
            svau_pkg::CMD_CLR_VBL:
            begin
                nx.vblank  = 1'b0;
                check_edge = 1'b1;
            end
            svau_pkg::CMD_TICK:
            begin
                if (state.nmi_count != 8'd0)
                begin
                    nx.nmi_count = count_dec;
                    pulse = (count_dec == 8'd0) && state.nmi_enable && state.vblank;
                end
            end
            default:
            begin
                nx = nx;
            end
        endcase

        // rising edge of enable and vblank loads the delay countdown
        nmi_cond = nx.nmi_enable & nx.vblank;
        if (check_edge)
        begin
            if (nmi_cond && !state.nmi_prev)
            begin
                nx.nmi_count = nmi_delay;
            end
            nx.nmi_prev = nmi_cond;
        end
    end

    assign state_next           = nx;
    assign result.read_byte     = rd;
    assign result.vram_address  = nx.cur_addr;
    assign result.fine_x_scroll = nx.fine_x;
    assign result.nmi_pulse     = pulse;

endmodule

[design/scroll_vram_address_unit.sv]
// result: offered in the cycle after its command transaction is accepted
// throughput: one command per cycle while results are taken, set by the single
// register-to-register pass through the next-state logic; the output register lets a new
// command in while the result is being taken
// reset: rst_n clears all scroll, address and nmi state; nmi delay returns to 15
module scroll_vram_address_unit
(
    input  logic        clk,
    input  logic        rst_n,
    svau_cmd_if.sink    cmd_ch,
    svau_res_if.source  res_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // architectural state and the delay register
    svau_pkg::svau_state_t  state_reg;
    svau_pkg::svau_state_t  state_next;
    logic [7:0]             nmi_delay_reg;

    // output register
    svau_pkg::svau_result_t result_reg;
    svau_pkg::svau_result_t result_next;
    logic                   res_valid_reg;

    logic cmd_accept;
    logic cfg_write;

    // the output register frees up whenever its transaction completes this cycle
    assign cmd_ch.ready = !res_valid_reg || res_ch.ready;
    assign cmd_accept   = cmd_ch.valid && cmd_ch.ready;

    // apb: zero wait state, register index taken from address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            svau_pkg::REG_NMI_DELAY: prdata = {24'd0, nmi_delay_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmi_delay_reg <= svau_pkg::NMI_DELAY_RESET;
        end
        else if (cfg_write && (paddr[2] == svau_pkg::REG_NMI_DELAY))
        begin
            nmi_delay_reg <= pwdata[7:0];
        end
    end

    // all per-command work lives in the core, between state_reg and result_reg
    svau_core u_core
    (
        .state           (state_reg),
        .cmd             (cmd_ch.cmd),
        .data_byte       (cmd_ch.data_byte),
        .sprite_overflow (cmd_ch.sprite_overflow),
        .sprite_zero_hit (cmd_ch.sprite_zero_hit),
        .nmi_delay       (nmi_delay_reg),
        .state_next      (state_next),
        .result          (result_next)
    );

    // state only moves on an accepted command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign res_ch.valid         = res_valid_reg;
    assign res_ch.read_byte     = result_reg.read_byte;
    assign res_ch.vram_address  = result_reg.vram_address;
    assign res_ch.fine_x_scroll = result_reg.fine_x_scroll;
    assign res_ch.nmi_pulse     = result_reg.nmi_pulse;

endmodule

[design/svau_checker.sv]
module svau_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_read_byte,
    input logic       res_nmi_pulse
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // every accepted command yields a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> res_valid)
        else $error("accepted command gave no result");

    // an empty output register never blocks the command side
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> in_ready)
        else $error("command side stalled with empty output");

    // nmi only fires on a tick, which never reads status
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_nmi_pulse |-> res_read_byte == 8'd0)
        else $error("nmi pulse together with a status byte");

endmodule

bind scroll_vram_address_unit svau_checker u_svau_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cmd_ch.valid),
    .in_ready      (cmd_ch.ready),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_read_byte (res_ch.read_byte),
    .res_nmi_pulse (res_ch.nmi_pulse)
);
